FILE: rtl/rotation_matrix_to_quaternion_assert.svh
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rmq: same-cycle check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rmq: next-cycle check failed");

`endif

FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: package
// Widths, pipeline depths and the square root step.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  typedef logic signed [15:0] q14_t;

  localparam int V_W        = 18;
  localparam int A_W        = 17;
  localparam int SQ_W       = 34;
  localparam int N_W        = 35;
  localparam int REM_W      = 36;
  localparam int Q_W        = 31;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam int ROOT_W     = 32;
  localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS + 1;
  localparam int FRONT_LAT  = 3;
  localparam int PIPE_LAT   = FRONT_LAT + LANE_LAT;
  localparam int ONE_Q14    = 16384;

  typedef logic signed [V_W-1:0] vec_t;

  typedef struct packed {
    logic [Q_W-1:0]    rad;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [ROOT_W-1:0] bitv);
    logic [ROOT_W-1:0] trial;
    sqrt_st_t          r;
    trial = s.root + bitv;
    if ({1'b0, s.rad} >= trial) begin
      r.rad  = s.rad - trial[Q_W-1:0];
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.rad  = s.rad;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: channel interfaces
// Matrix word in, quaternion word out, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_mat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  q14_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                output ready);
endinterface

interface rmq_quat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  q14_t quat_x, quat_y, quat_z, quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Shepperd branch selection, then exact fixed-point normalisation.
// ----------------------------------------------------------------------------
// Takes one matrix word per cycle and returns the unit quaternion. Stage 1
// picks the branch and forms the unscaled vector, stage 2 squares each entry,
// stage 3 sums the squares. Each of four lanes then runs a 31-stage restoring
// divider, a 16-stage square root and a rounding stage. The whole pipeline
// advances as one: it holds only while a result waits at the output, and
// accepts a new word in every cycle otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion (
  input wire logic   clk,
  input wire logic   rst,
  rmq_mat_if.sink    matrix,
  rmq_quat_if.source quat
);
  import rmq_pkg::*;

  logic                en;
  logic [PIPE_LAT-1:0] vld;

  assign en           = !vld[PIPE_LAT-1] || quat.ready;
  assign matrix.ready = en;
  assign quat.valid   = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], matrix.valid};
    end
  end

  // branch select
  logic signed [V_W:0] t;
  logic signed [V_W:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [V_W:0] v_next [4];
  localparam logic signed [V_W:0] ONE = (V_W+1)'(ONE_Q14);

  assign e00 = (V_W+1)'(matrix.r00);
  assign e01 = (V_W+1)'(matrix.r01);
  assign e02 = (V_W+1)'(matrix.r02);
  assign e10 = (V_W+1)'(matrix.r10);
  assign e11 = (V_W+1)'(matrix.r11);
  assign e12 = (V_W+1)'(matrix.r12);
  assign e20 = (V_W+1)'(matrix.r20);
  assign e21 = (V_W+1)'(matrix.r21);
  assign e22 = (V_W+1)'(matrix.r22);
  assign t   = e00 + e11 + e22;

  always_comb begin
    if (t > -ONE) begin
      v_next[0] = e12 - e21;
      v_next[1] = e20 - e02;
      v_next[2] = e01 - e10;
      v_next[3] = t + ONE;
    end else if (e00 > e11 && e00 > e22) begin
      v_next[0] = ONE + e00 - e11 - e22;
      v_next[1] = e01 + e10;
      v_next[2] = e02 + e20;
      v_next[3] = e12 - e21;
    end else if (e11 > e22) begin
      v_next[0] = e01 + e10;
      v_next[1] = ONE + e11 - e00 - e22;
      v_next[2] = e12 + e21;
      v_next[3] = e20 - e02;
    end else begin
      v_next[0] = e02 + e20;
      v_next[1] = e12 + e21;
      v_next[2] = ONE + e22 - e00 - e11;
      v_next[3] = e01 - e10;
    end
  end

  vec_t            v1   [4];
  logic [SQ_W-1:0] sq2  [4];
  logic            neg2 [4];
  logic [SQ_W-1:0] sq3  [4];
  logic            neg3 [4];
  logic [N_W-1:0]  n3;
  q14_t            qo   [4];

  for (genvar k = 0; k < 4; k++) begin : g_front
    logic [A_W-1:0] a;
    assign a = v1[k][V_W-1] ? A_W'(-v1[k]) : A_W'(v1[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        v1[k]   <= V_W'(v_next[k]);
        sq2[k]  <= a * a;
        neg2[k] <= v1[k][V_W-1];
        sq3[k]  <= sq2[k];
        neg3[k] <= neg2[k];
      end
    end

    rmq_lane u_lane (
      .clk (clk),
      .en  (en),
      .sq  (sq3[k]),
      .n   (n3),
      .neg (neg3[k]),
      .q   (qo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= N_W'(sq2[0]) + N_W'(sq2[1]) + N_W'(sq2[2]) + N_W'(sq2[3]);
    end
  end

  assign quat.quat_x = qo[0];
  assign quat.quat_y = qo[1];
  assign quat.quat_z = qo[2];
  assign quat.quat_w = qo[3];

  `RMQ_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, vld == $past(vld))
  `RMQ_ASSERT_IMPLIES(a_norm_nonzero, clk, rst, vld[FRONT_LAT-1], n3 != '0)
  `RMQ_ASSERT_IMPLIES(a_sq_le_norm, clk, rst, vld[FRONT_LAT-1], N_W'(sq3[0]) <= n3)
  `RMQ_ASSERT_IMPLIES(a_unit_range, clk, rst, quat.valid,
    quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384)

endmodule

`default_nettype wire

FILE: rtl/rmq_lane.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: normalising lane
// One component: restoring divide of sq * 2^30 by n, one bit a stage, then
// a bit-pair square root, one root bit a stage, then round and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_lane (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [rmq_pkg::SQ_W-1:0] sq,
  input  wire logic [rmq_pkg::N_W-1:0]  n,
  input  wire logic                   neg,
  output rmq_pkg::q14_t               q
);
  import rmq_pkg::*;

  logic [REM_W-1:0] rem   [DIV_STEPS];
  logic [Q_W-1:0]   quo   [DIV_STEPS];
  logic [N_W-1:0]   nd    [DIV_STEPS];
  logic             sgn_d [DIV_STEPS];
  sqrt_st_t         sst   [SQRT_STEPS];
  logic             sgn_s [SQRT_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [REM_W-1:0] shifted;
    logic [N_W-1:0]   dvs;
    logic [Q_W-1:0]   quo_prev;
    logic             sgn_prev;
    logic             ge;
    if (i == 0) begin : g_first
      assign shifted  = {{(REM_W-SQ_W){1'b0}}, sq};
      assign dvs      = n;
      assign quo_prev = '0;
      assign sgn_prev = neg;
    end else begin : g_rest
      assign shifted  = {rem[i-1][REM_W-2:0], 1'b0};
      assign dvs      = nd[i-1];
      assign quo_prev = quo[i-1];
      assign sgn_prev = sgn_d[i-1];
    end
    assign ge = shifted >= {1'b0, dvs};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]   <= ge ? shifted - {1'b0, dvs} : shifted;
        nd[i]    <= dvs;
        quo[i]   <= {quo_prev[Q_W-2:0], ge};
        sgn_d[i] <= sgn_prev;
      end
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [ROOT_W-1:0] SQ_BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    sqrt_st_t prev;
    logic     sgn_prev;
    if (j == 0) begin : g_first
      assign prev.rad  = quo[DIV_STEPS-1];
      assign prev.root = '0;
      assign sgn_prev  = sgn_d[DIV_STEPS-1];
    end else begin : g_rest
      assign prev     = sst[j-1];
      assign sgn_prev = sgn_s[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sst[j]   <= sqrt_step(prev, SQ_BIT);
        sgn_s[j] <= sgn_prev;
      end
    end
  end

  logic [16:0] rnd;
  logic [15:0] mag;
  logic [15:0] cap;

  assign rnd = sst[SQRT_STEPS-1].root[16:0] + 17'd1;
  assign mag = rnd[16:1];
  assign cap = (mag > 16'(ONE_Q14)) ? 16'(ONE_Q14) : mag;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sgn_s[SQRT_STEPS-1] ? -$signed(cap) : $signed(cap);
    end
  end

endmodule

`default_nettype wire

FILE: tb/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: testbench
// Drives matrix words with random gaps and output stalls, predicts each
// quaternion from the branch selection and exact normalisation, and compares
// every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef struct packed {
    q14_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  } matrix_t;

  typedef struct packed {
    q14_t x, y, z, w;
  } quat_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_mat_if  matrix ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst), .matrix(matrix.sink), .quat(quat.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_t pending[$];
  quat_t   expected[$];
  int      errors = 0;
  int      cycles = 0;
  int      sent = 0;
  int      received = 0;
  bit      quiet = 1'b0;
  bit      hold_off = 1'b0;
  int      gap = 0;
  int      stall = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic q14_t unit_component(longint v, longint unsigned n);
    longint unsigned a, f, q;
    a = (v < 0) ? -v : v;
    f = ((a * a) << 30) / n;
    q = (int_sqrt(f) + 1) >> 1;
    if (q > ONE_Q14) q = ONE_Q14;
    return (v < 0) ? q14_t'(-longint'(q)) : q14_t'(q);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, t;
    longint v[4];
    longint unsigned n;
    quat_t q;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    t = a00 + a11 + a22;
    if (t > -ONE_Q14) begin
      v[0] = a12 - a21; v[1] = a20 - a02; v[2] = a01 - a10; v[3] = t + ONE_Q14;
    end else if (a00 > a11 && a00 > a22) begin
      v[0] = ONE_Q14 + a00 - a11 - a22; v[1] = a01 + a10;
      v[2] = a02 + a20; v[3] = a12 - a21;
    end else if (a11 > a22) begin
      v[0] = a01 + a10; v[1] = ONE_Q14 + a11 - a00 - a22;
      v[2] = a12 + a21; v[3] = a20 - a02;
    end else begin
      v[0] = a02 + a20; v[1] = a12 + a21;
      v[2] = ONE_Q14 + a22 - a00 - a11; v[3] = a01 - a10;
    end
    n = 0;
    for (int i = 0; i < 4; i++) n += longint'(v[i] * v[i]);
    if (n == 0) n = 1;
    q.x = unit_component(v[0], n);
    q.y = unit_component(v[1], n);
    q.z = unit_component(v[2], n);
    q.w = unit_component(v[3], n);
    return q;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d (word %0d)", what, got, want, received);
  endtask

  function automatic q14_t rnd16();
    return q14_t'($urandom);
  endfunction

  function automatic q14_t near(int c);
    return q14_t'(c + $urandom_range(0, 800) - 400);
  endfunction

  function automatic matrix_t rnd_matrix();
    matrix_t m;
    int sel;
    sel = $urandom_range(0, 9);
    m = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
    if (sel < 6) begin
      // near a signed permutation: every branch gets visited
      int p, s0, s1, s2;
      p = $urandom_range(0, 5);
      s0 = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
      s1 = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
      s2 = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
      m = {near(0), near(0), near(0), near(0), near(0), near(0), near(0), near(0), near(0)};
      case (p)
        0: begin m.r00 = near(s0); m.r11 = near(s1); m.r22 = near(s2); end
        1: begin m.r01 = near(s0); m.r10 = near(s1); m.r22 = near(s2); end
        2: begin m.r02 = near(s0); m.r11 = near(s1); m.r20 = near(s2); end
        3: begin m.r00 = near(s0); m.r12 = near(s1); m.r21 = near(s2); end
        4: begin m.r01 = near(s0); m.r12 = near(s1); m.r20 = near(s2); end
        default: begin m.r02 = near(s0); m.r10 = near(s1); m.r21 = near(s2); end
      endcase
    end
    return m;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      matrix.valid <= 1'b0;
      quat.ready <= 1'b0;
    end else begin
      if (matrix.valid && matrix.ready) begin
        expected.push_back(matrix_to_quat({matrix.r00, matrix.r01, matrix.r02,
          matrix.r10, matrix.r11, matrix.r12, matrix.r20, matrix.r21, matrix.r22}));
        sent <= sent + 1;
      end
      if (!matrix.valid || matrix.ready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          matrix.valid <= 1'b0;
        end else if (pending.size() > 0 && !hold_off) begin
          matrix_t m;
          m = pending.pop_front();
          {matrix.r00, matrix.r01, matrix.r02, matrix.r10, matrix.r11, matrix.r12,
           matrix.r20, matrix.r21, matrix.r22} <= m;
          matrix.valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 3);
        end else begin
          matrix.valid <= 1'b0;
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        quat.ready <= 1'b0;
      end else begin
        quat.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall <= $urandom_range(1, 3);
      end
    end
    if (quat.valid && quat.ready && !rst) begin
      if (expected.size() == 0) begin
        errors++;
        $display("unexpected quaternion word %0d", received);
      end else begin
        quat_t e;
        e = expected.pop_front();
        if (quat.quat_x !== e.x) report("quat_x", quat.quat_x, e.x);
        if (quat.quat_y !== e.y) report("quat_y", quat.quat_y, e.y);
        if (quat.quat_z !== e.z) report("quat_z", quat.quat_z, e.z);
        if (quat.quat_w !== e.w) report("quat_w", quat.quat_w, e.w);
      end
      received <= received + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    q14_t ext[4];
    matrix.valid = 1'b0;
    {matrix.r00, matrix.r01, matrix.r02, matrix.r10, matrix.r11, matrix.r12,
     matrix.r20, matrix.r21, matrix.r22} = '0;
    quat.ready = 1'b0;
    ext = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    pending.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                       16'sd0, 16'sd0, 16'sd16384});
    pending.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                       16'sd0, 16'sd0, -16'sd16384});
    pending.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                       16'sd0, 16'sd0, -16'sd16384});
    pending.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                       16'sd0, 16'sd0, 16'sd16384});
    pending.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                       16'sd0, 16'sd0, -16'sd16384});
    pending.push_back('0);
    pending.push_back({9{16'sh7fff}});
    pending.push_back({9{-16'sh8000}});
    pending.push_back({9{-16'sd1}});
    pending.push_back({-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
                       16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000});
    pending.push_back({-16'sd5462, 16'sd0, 16'sd0, 16'sd0, -16'sd5461, 16'sd0,
                       16'sd0, 16'sd0, -16'sd5461});
    for (int i = 0; i < 12; i++) begin
      m = {ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
           ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
           ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)]};
      pending.push_back(m);
    end
    for (int i = 0; i < 900; i++) pending.push_back(rnd_matrix());

    wait (pending.size() == 0);
    hold_off = 1'b1;
    wait (expected.size() == 0 && !matrix.valid);
    hold_off = 1'b0;

    for (int i = 0; i < 750; i++) pending.push_back(rnd_matrix());
    wait (pending.size() == 0);
    quiet = 1'b1;
    for (int i = 0; i < 300; i++) pending.push_back(rnd_matrix());
    wait (pending.size() == 0);
    @(posedge clk);
    while (matrix.valid) @(posedge clk);
    wait (expected.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);

    $display("Converted %0d matrices (identity, all branches, field extremes, random)", sent);
    $display("with random input gaps and output stalls; %0d quaternions checked", received);
    if (errors == 0 && expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
